@@ hdl/ppc_pkg.sv @@
package ppc_pkg;

    localparam int IDX_W      = 6;
    localparam int IDX_SLOTS  = 64;
    localparam int COORD_W    = 22;
    localparam int SPEED_W    = 14;
    localparam int TIME_W     = 32;
    localparam int EPS_W      = 10;
    localparam int SF_W       = 8;
    localparam int EPS_SQ_W   = 2 * EPS_W;
    localparam int RATE_W     = SPEED_W + SF_W;
    localparam int REACH_W    = RATE_W + TIME_W;
    localparam int HALF_W     = 32;
    localparam int PHI_W      = REACH_W - HALF_W;
    localparam int PLL_W      = 2 * HALF_W;
    localparam int PLH_W      = HALF_W + PHI_W;
    localparam int PHH_W      = 2 * PHI_W;
    localparam int P2_W       = 2 * REACH_W;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int D2_W       = SQ_W + 1;
    localparam int D2HI_W     = D2_W - HALF_W;
    localparam int SCALE_W    = 28;
    localparam int L0_W       = HALF_W + SCALE_W;
    localparam int L1_W       = D2HI_W + SCALE_W;
    localparam int LHS_W      = D2_W + SCALE_W;
    localparam int CNT_W      = 32;
    localparam int IN_DATA_W  = 96;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 4 * CNT_W;
    localparam int OUT_USER_W = 4;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    localparam logic [SCALE_W-1:0] SCALE_SQ = 28'd256000000;

    localparam logic [CFG_IDX_W-1:0] CFG_FROZEN_EPS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVING_SPEED  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAFETY_FACTOR = 2'd2;

    localparam logic [EPS_W-1:0]   EPS_RESET    = 10'd5;
    localparam logic [SPEED_W-1:0] MOVING_RESET = 14'd50;
    localparam logic [SF_W-1:0]    SF_RESET     = 8'd24;

    typedef enum logic [2:0] {
        VERDICT_FIRST  = 3'd0,
        VERDICT_ACCEPT = 3'd1,
        VERDICT_SKIP   = 3'd2,
        VERDICT_FROZEN = 3'd3,
        VERDICT_JUMP   = 3'd4
    } t_verdict;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_LOOKUP,
        B_MUL1,
        B_MUL2,
        B_MUL3,
        B_DECIDE
    } t_back_state;

    typedef struct packed {
        logic [IDX_W-1:0]   slot;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [TIME_W-1:0]  stamp;
        logic [RATE_W-1:0]  rate;
        logic               moving;
        logic               attack;
    } t_item;

    typedef struct packed {
        logic [CNT_W-1:0] fn;
        logic [CNT_W-1:0] fp;
        logic [CNT_W-1:0] tn;
        logic [CNT_W-1:0] tp;
    } t_counts;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

endpackage

@@ hdl/position_plausibility_checker.sv @@
// an accepted word goes through the front register, the two-entry queue and the table read, which alone
// decides a first or skipped message; a full check adds three multiply steps and a compare before the registered result
// flow: the single-item back end sequencer takes a new word only after the last one is finished,
// and a stalled output holds it there; the front register and queue hold words meanwhile
// reset: synchronous; clears VEHICLE_SLOTS valid bits one per cycle, no input taken meanwhile
module position_plausibility_checker import ppc_pkg::*; #(
    parameter int VEHICLE_SLOTS = 64,
    parameter int COORD_BITS = 22
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // vehicle_index, pos_x_cm, pos_y_cm, speed_cms, time_ms
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // labelled_attack
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // true_pos_count, true_neg_count, false_pos_count, false_neg_count
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // anomaly, verdict
    output logic [OUT_USER_W-1:0] m_axis_tuser,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [EPS_W-1:0]     r_frozen_eps;
    logic [SPEED_W-1:0]   r_moving_speed;
    logic [SF_W-1:0]      r_safety_factor;
    logic [CFG_IDX_W-1:0] w_cfg_idx;
    logic                 w_cfg_write;
    logic                 w_init_done;
    logic                 w_q_full;
    logic                 w_push;
    t_item                w_front_item;
    logic                 w_q_valid;
    logic                 w_q_pop;
    t_item                w_q_item;
    logic                 w_anomaly;
    t_verdict             w_verdict;
    t_counts              w_counts;

    assign pready      = 1'b1;
    assign w_cfg_idx   = paddr[CFG_ADDR_W-1:2];
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frozen_eps    <= EPS_RESET;
            r_moving_speed  <= MOVING_RESET;
            r_safety_factor <= SF_RESET;
        end else if (w_cfg_write) begin
            case (w_cfg_idx)
                CFG_FROZEN_EPS:    r_frozen_eps    <= pwdata[EPS_W-1:0];
                CFG_MOVING_SPEED:  r_moving_speed  <= pwdata[SPEED_W-1:0];
                CFG_SAFETY_FACTOR: r_safety_factor <= pwdata[SF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_cfg_idx)
            CFG_FROZEN_EPS:    prdata = CFG_DATA_W'(r_frozen_eps);
            CFG_MOVING_SPEED:  prdata = CFG_DATA_W'(r_moving_speed);
            CFG_SAFETY_FACTOR: prdata = CFG_DATA_W'(r_safety_factor);
            default:           prdata = '0;
        endcase
    end

    ppc_front #(.VEHICLE_SLOTS(VEHICLE_SLOTS), .COORD_BITS(COORD_BITS)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_enable        (w_init_done),
        .i_moving_speed  (r_moving_speed),
        .i_safety_factor (r_safety_factor),
        .i_tvalid        (s_axis_tvalid),
        .o_tready        (s_axis_tready),
        .i_tdata         (s_axis_tdata),
        .i_tuser         (s_axis_tuser),
        .i_q_full        (w_q_full),
        .o_push          (w_push),
        .o_item          (w_front_item)
    );

    ppc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    ppc_back #(.VEHICLE_SLOTS(VEHICLE_SLOTS), .COORD_BITS(COORD_BITS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_frozen_eps (r_frozen_eps),
        .i_q_valid    (w_q_valid),
        .i_q_item     (w_q_item),
        .o_q_pop      (w_q_pop),
        .o_init_done  (w_init_done),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_anomaly    (w_anomaly),
        .o_verdict    (w_verdict),
        .o_counts     (w_counts)
    );

    assign m_axis_tdata = w_counts;
    assign m_axis_tuser = {w_verdict, w_anomaly};

endmodule

@@ hdl/ppc_ram.sv @@
module ppc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/ppc_front.sv @@
module ppc_front import ppc_pkg::*; #(
    parameter int VEHICLE_SLOTS = 64,
    parameter int COORD_BITS = 22
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_enable,
    input  logic [SPEED_W-1:0]   i_moving_speed,
    input  logic [SF_W-1:0]      i_safety_factor,
    input  logic                 i_tvalid,
    output logic                 o_tready,
    input  logic [IN_DATA_W-1:0] i_tdata,
    input  logic [IN_USER_W-1:0] i_tuser,
    input  logic                 i_q_full,
    output logic                 o_push,
    output t_item                o_item
);

    localparam logic [COORD_W-1:0] COORD_MASK = (COORD_BITS >= COORD_W) ?
        {COORD_W{1'b1}} : COORD_W'((64'd1 << COORD_BITS) - 64'd1);

    logic [IDX_W-1:0]   w_slot_map [IDX_SLOTS];
    logic [IDX_W-1:0]   w_index;
    logic [COORD_W-1:0] w_x;
    logic [COORD_W-1:0] w_y;
    logic [SPEED_W-1:0] w_speed;
    logic [TIME_W-1:0]  w_stamp;
    logic               w_accept;
    logic               r_valid;
    t_item              r_item;

    for (genvar g = 0; g < IDX_SLOTS; g++) begin : g_slot_map
        assign w_slot_map[g] = IDX_W'(g % VEHICLE_SLOTS);
    end

    assign w_index = i_tdata[5:0];
    assign w_x     = i_tdata[27:6];
    assign w_y     = i_tdata[49:28];
    assign w_speed = i_tdata[63:50];
    assign w_stamp = i_tdata[95:64];

    assign o_push   = r_valid && !i_q_full;
    assign o_tready = i_enable && (!r_valid || !i_q_full);
    assign w_accept = i_tvalid && o_tready;
    assign o_item   = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.slot   <= w_slot_map[w_index];
            r_item.x      <= w_x & COORD_MASK;
            r_item.y      <= w_y & COORD_MASK;
            r_item.stamp  <= w_stamp;
            r_item.rate   <= RATE_W'(w_speed) * RATE_W'(i_safety_factor);
            r_item.moving <= w_speed > i_moving_speed;
            r_item.attack <= i_tuser[0];
        end
    end

endmodule

@@ hdl/ppc_queue.sv @@
module ppc_queue import ppc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_QW = $clog2(DEPTH + 1);

    t_item             r_slots [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_QW-1:0] r_count;
    logic              w_do_push;
    logic              w_do_pop;

    assign o_full    = r_count == CNT_QW'(DEPTH);
    assign o_valid   = r_count != '0;
    assign o_item    = r_slots[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + CNT_QW'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - CNT_QW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_slots[r_wr_ptr] <= i_item;
        end
    end

endmodule

@@ hdl/ppc_back.sv @@
module ppc_back import ppc_pkg::*; #(
    parameter int VEHICLE_SLOTS = 64,
    parameter int COORD_BITS = 22
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [EPS_W-1:0] i_frozen_eps,
    input  logic             i_q_valid,
    input  t_item            i_q_item,
    output logic             o_q_pop,
    output logic             o_init_done,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic             o_anomaly,
    output t_verdict         o_verdict,
    output t_counts          o_counts
);

    localparam int SLOT_BITS = $clog2(VEHICLE_SLOTS);
    localparam int CW = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
    localparam int REC_W = 2 * CW + TIME_W;
    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(VEHICLE_SLOTS - 1);

    t_back_state r_state, n_state;
    logic [SLOT_BITS-1:0] r_clr_addr;
    t_item                r_cur;
    logic [COORD_W-1:0]   r_dx, r_dy;
    logic [TIME_W-1:0]    r_dt;
    logic [SQ_W-1:0]      r_dxx, r_dyy;
    logic [REACH_W-1:0]   r_reach;
    logic                 r_reach_nz;
    logic [D2_W-1:0]      r_d2;
    logic [PLL_W-1:0]     r_pll;
    logic [PLH_W-1:0]     r_plh;
    logic [PHH_W-1:0]     r_phh;
    logic [P2_W-1:0]      r_p2;
    logic [L0_W-1:0]      r_l0;
    logic [L1_W-1:0]      r_l1;
    logic                 r_frozen;
    logic                 r_out_valid;
    logic                 r_anomaly;
    t_verdict             r_verdict;
    t_counts              r_counts, n_counts;

    logic                 w_v_rdata;
    logic                 w_v_we;
    logic                 w_v_wdata;
    logic [REC_W-1:0]     w_rec_rdata;
    logic [REC_W-1:0]     w_rec_wdata;
    logic                 w_rec_we;
    logic                 w_re;
    logic [SLOT_BITS-1:0] w_waddr;
    logic [SLOT_BITS-1:0] w_cur_addr;
    logic [SLOT_BITS-1:0] w_head_addr;
    logic [COORD_W-1:0]   w_last_x, w_last_y;
    logic [TIME_W-1:0]    w_last_time;
    logic                 w_time_ok;
    logic [COORD_W-1:0]   w_dx, w_dy;
    logic [HALF_W-1:0]    w_plo;
    logic [PHI_W-1:0]     w_phi;
    logic [EPS_SQ_W-1:0]  w_eps_sq;
    logic [LHS_W-1:0]     w_lhs;
    logic                 w_jump;
    logic                 w_out_free;
    logic                 w_finish;
    logic                 w_anom;
    t_verdict             w_verdict;

    assign w_cur_addr  = SLOT_BITS'(r_cur.slot);
    assign w_head_addr = SLOT_BITS'(i_q_item.slot);
    assign w_rec_wdata = {r_cur.stamp, r_cur.y[CW-1:0], r_cur.x[CW-1:0]};

    ppc_ram #(.WIDTH(1), .DEPTH(VEHICLE_SLOTS)) u_valid_ram (
        .i_clk   (i_clk),
        .i_we    (w_v_we),
        .i_waddr (w_waddr),
        .i_wdata (w_v_wdata),
        .i_re    (w_re),
        .i_raddr (w_head_addr),
        .o_rdata (w_v_rdata)
    );

    ppc_ram #(.WIDTH(REC_W), .DEPTH(VEHICLE_SLOTS)) u_record_ram (
        .i_clk   (i_clk),
        .i_we    (w_rec_we),
        .i_waddr (w_cur_addr),
        .i_wdata (w_rec_wdata),
        .i_re    (w_re),
        .i_raddr (w_head_addr),
        .o_rdata (w_rec_rdata)
    );

    assign w_last_x    = COORD_W'(w_rec_rdata[CW-1:0]);
    assign w_last_y    = COORD_W'(w_rec_rdata[2*CW-1:CW]);
    assign w_last_time = w_rec_rdata[REC_W-1:2*CW];
    assign w_time_ok   = r_cur.stamp > w_last_time;
    assign w_dx = (r_cur.x >= w_last_x) ? r_cur.x - w_last_x : w_last_x - r_cur.x;
    assign w_dy = (r_cur.y >= w_last_y) ? r_cur.y - w_last_y : w_last_y - r_cur.y;

    assign w_plo    = r_reach[HALF_W-1:0];
    assign w_phi    = r_reach[REACH_W-1:HALF_W];
    assign w_eps_sq = EPS_SQ_W'(i_frozen_eps) * EPS_SQ_W'(i_frozen_eps);

    assign w_lhs  = LHS_W'(r_l0) + (LHS_W'(r_l1) << HALF_W);
    assign w_jump = !r_frozen && r_reach_nz && (P2_W'(w_lhs) > r_p2);

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_CLEAR: begin
                if (r_clr_addr == LAST_SLOT) n_state = B_IDLE;
            end
            B_IDLE: begin
                if (i_q_valid) n_state = B_LOOKUP;
            end
            B_LOOKUP: begin
                if (w_v_rdata && w_time_ok) n_state = B_MUL1;
                else if (w_out_free) n_state = B_IDLE;
            end
            B_MUL1: n_state = B_MUL2;
            B_MUL2: n_state = B_MUL3;
            B_MUL3: n_state = B_DECIDE;
            B_DECIDE: begin
                if (w_out_free) n_state = B_IDLE;
            end
            default: n_state = B_CLEAR;
        endcase
    end

    always_comb begin
        w_v_we    = 1'b0;
        w_v_wdata = 1'b0;
        w_waddr   = w_cur_addr;
        w_rec_we  = 1'b0;
        w_re      = 1'b0;
        o_q_pop   = 1'b0;
        w_finish  = 1'b0;
        w_anom    = 1'b0;
        w_verdict = VERDICT_ACCEPT;
        case (r_state)
            B_CLEAR: begin
                w_v_we  = 1'b1;
                w_waddr = r_clr_addr;
            end
            B_IDLE: begin
                w_re    = i_q_valid;
                o_q_pop = i_q_valid;
            end
            B_LOOKUP: begin
                if (!w_v_rdata) begin
                    w_finish  = w_out_free;
                    w_v_we    = w_out_free;
                    w_v_wdata = 1'b1;
                    w_rec_we  = w_out_free;
                    w_verdict = VERDICT_FIRST;
                end else if (!w_time_ok) begin
                    w_finish  = w_out_free;
                    w_verdict = VERDICT_SKIP;
                end
            end
            B_DECIDE: begin
                w_finish = w_out_free;
                if (r_frozen) begin
                    w_anom    = 1'b1;
                    w_verdict = VERDICT_FROZEN;
                end else if (w_jump) begin
                    w_anom    = 1'b1;
                    w_verdict = VERDICT_JUMP;
                end else begin
                    w_rec_we = w_out_free;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_counts = r_counts;
        if (r_cur.attack) begin
            if (w_anom) n_counts.tp = sat_inc(r_counts.tp);
            else n_counts.fn = sat_inc(r_counts.fn);
        end else begin
            if (w_anom) n_counts.fp = sat_inc(r_counts.fp);
            else n_counts.tn = sat_inc(r_counts.tn);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_counts    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == B_CLEAR) begin
                r_clr_addr <= r_clr_addr + SLOT_BITS'(1);
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
                r_counts    <= n_counts;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cur <= i_q_item;
        end
        if (r_state == B_LOOKUP) begin
            r_dx <= w_dx;
            r_dy <= w_dy;
            r_dt <= r_cur.stamp - w_last_time;
        end
        if (r_state == B_MUL1) begin
            r_dxx   <= SQ_W'(r_dx) * SQ_W'(r_dx);
            r_dyy   <= SQ_W'(r_dy) * SQ_W'(r_dy);
            r_reach <= REACH_W'(r_cur.rate) * REACH_W'(r_dt);
        end
        if (r_state == B_MUL2) begin
            r_d2       <= D2_W'(r_dxx) + D2_W'(r_dyy);
            r_pll      <= PLL_W'(w_plo) * PLL_W'(w_plo);
            r_plh      <= PLH_W'(w_plo) * PLH_W'(w_phi);
            r_phh      <= PHH_W'(w_phi) * PHH_W'(w_phi);
            r_reach_nz <= r_reach != '0;
        end
        if (r_state == B_MUL3) begin
            // cross term counted twice, hence one extra bit of shift
            r_p2 <= P2_W'(r_pll) + (P2_W'(r_plh) << (HALF_W + 1))
                    + (P2_W'(r_phh) << (2 * HALF_W));
            r_l0 <= L0_W'(r_d2[HALF_W-1:0]) * L0_W'(SCALE_SQ);
            r_l1 <= L1_W'(r_d2[D2_W-1:HALF_W]) * L1_W'(SCALE_SQ);
            r_frozen <= (r_d2 < D2_W'(w_eps_sq)) && r_cur.moving;
        end
        if (w_finish) begin
            r_anomaly <= w_anom;
            r_verdict <= w_verdict;
        end
    end

    assign o_init_done = r_state != B_CLEAR;
    assign o_out_valid = r_out_valid;
    assign o_anomaly   = r_anomaly;
    assign o_verdict   = r_verdict;
    assign o_counts    = r_counts;

endmodule

@@ hdl/ppc_checker.sv @@
module ppc_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata,
    input logic [3:0]   m_axis_tuser
);

    // nothing comes out straight after reset
    a_reset_out: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // table clearing holds off input after reset
    a_reset_in: assert property (@(posedge i_clk) !i_rst_n |=> !s_axis_tready)
        else $error("input ready during table clearing");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result word changed");

    // confusion counters never go down
    a_counts_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready |=>
            (m_axis_tdata[31:0] >= $past(m_axis_tdata[31:0])) &&
            (m_axis_tdata[63:32] >= $past(m_axis_tdata[63:32])) &&
            (m_axis_tdata[95:64] >= $past(m_axis_tdata[95:64])) &&
            (m_axis_tdata[127:96] >= $past(m_axis_tdata[127:96])))
        else $error("counter decreased");

endmodule

bind position_plausibility_checker ppc_checker u_ppc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

@@ dv/testbench.sv @@
module testbench;
    import ppc_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned SETTLE_CYCLES  = 12;
    localparam int unsigned PHASES         = 6;
    localparam int unsigned PHASE_WORDS    = 134;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [COORD_W-1:0] COORD_MAX = {COORD_W{1'b1}};
    localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};

    typedef struct packed {
        logic [IDX_W-1:0]   slot;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [SPEED_W-1:0] speed;
        logic [TIME_W-1:0]  stamp;
        logic               attack;
    } t_message;

    typedef struct packed {
        logic     anomaly;
        t_verdict verdict;
        t_counts  counts;
    } t_outcome;

    class plausibility_scoreboard;
        logic [EPS_W-1:0]   eps;
        logic [SPEED_W-1:0] moving;
        logic [SF_W-1:0]    sf;
        bit                 slot_valid [IDX_SLOTS];
        logic [COORD_W-1:0] last_x [IDX_SLOTS];
        logic [COORD_W-1:0] last_y [IDX_SLOTS];
        logic [TIME_W-1:0]  last_time [IDX_SLOTS];
        t_counts            totals;
        t_outcome           expected_outcomes [$];
        int unsigned        errors;

        function new();
            eps = EPS_RESET;
            moving = MOVING_RESET;
            sf = SF_RESET;
            foreach (slot_valid[i]) slot_valid[i] = 1'b0;
            totals = '0;
            errors = 0;
        endfunction

        function void set_register(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_FROZEN_EPS:    eps = value[EPS_W-1:0];
                CFG_MOVING_SPEED:  moving = value[SPEED_W-1:0];
                CFG_SAFETY_FACTOR: sf = value[SF_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_message(input t_message m);
            t_outcome           r;
            logic [COORD_W-1:0] dx;
            logic [COORD_W-1:0] dy;
            logic [TIME_W-1:0]  dt;
            logic [127:0]       dist_sq;
            logic [127:0]       reach;
            bit                 frozen;
            bit                 jump;
            r = '0;
            if (!slot_valid[m.slot]) begin
                slot_valid[m.slot] = 1'b1;
                last_x[m.slot] = m.x;
                last_y[m.slot] = m.y;
                last_time[m.slot] = m.stamp;
                r.verdict = VERDICT_FIRST;
            end else if (m.stamp <= last_time[m.slot]) begin
                r.verdict = VERDICT_SKIP;
            end else begin
                dt = m.stamp - last_time[m.slot];
                dx = (m.x >= last_x[m.slot]) ? m.x - last_x[m.slot] : last_x[m.slot] - m.x;
                dy = (m.y >= last_y[m.slot]) ? m.y - last_y[m.slot] : last_y[m.slot] - m.y;
                dist_sq = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy);
                reach = 128'(m.speed) * 128'(dt) * 128'(sf);
                frozen = (dist_sq < 128'(eps) * 128'(eps)) && (m.speed > moving);
                jump = !frozen && (reach != 0) && (dist_sq * 128'(SCALE_SQ) > reach * reach);
                if (frozen) begin
                    r.anomaly = 1'b1;
                    r.verdict = VERDICT_FROZEN;
                end else if (jump) begin
                    r.anomaly = 1'b1;
                    r.verdict = VERDICT_JUMP;
                end else begin
                    last_x[m.slot] = m.x;
                    last_y[m.slot] = m.y;
                    last_time[m.slot] = m.stamp;
                    r.verdict = VERDICT_ACCEPT;
                end
            end
            if (m.attack && r.anomaly) begin
                if (totals.tp != '1) totals.tp++;
            end else if (m.attack) begin
                if (totals.fn != '1) totals.fn++;
            end else if (r.anomaly) begin
                if (totals.fp != '1) totals.fp++;
            end else begin
                if (totals.tn != '1) totals.tn++;
            end
            r.counts = totals;
            expected_outcomes.insert(expected_outcomes.size(), r);
        endfunction

        task report(input string what);
            errors++;
            $display("mismatch at %0t: %s", $time, what);
        endtask

        task check_result(input t_outcome got);
            t_outcome    want;
            logic [31:0] g [6];
            logic [31:0] w [6];
            string       names [6];
            names = '{"anomaly", "verdict", "true_pos", "true_neg", "false_pos", "false_neg"};
            if (expected_outcomes.size() == 0) begin
                report("result word with nothing expected");
                return;
            end
            want = expected_outcomes[0];
            expected_outcomes.delete(0);
            g = '{32'(got.anomaly), 32'(got.verdict), got.counts.tp, got.counts.tn,
                  got.counts.fp, got.counts.fn};
            w = '{32'(want.anomaly), 32'(want.verdict), want.counts.tp, want.counts.tn,
                  want.counts.fp, want.counts.fn};
            foreach (g[i]) begin
                if (g[i] !== w[i]) begin
                    report($sformatf("%s got %0d want %0d", names[i], g[i], w[i]));
                end
            end
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // vehicle_index, pos_x_cm, pos_y_cm, speed_cms, time_ms
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // labelled_attack
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // true_pos_count, true_neg_count, false_pos_count, false_neg_count
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // anomaly, verdict
    logic [OUT_USER_W-1:0] m_axis_tuser;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    plausibility_scoreboard sb;
    bit                     calm_send = 1'b0;
    bit                     calm_recv = 1'b0;
    int unsigned            idle_cycles = 0;

    position_plausibility_checker u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [COORD_W-1:0] nudge(input logic [COORD_W-1:0] base,
                                                 input int unsigned d);
        if ($urandom_range(1, 0) == 1 && 32'(base) >= d) return base - COORD_W'(d);
        if (32'(base) + d <= 32'(COORD_MAX)) return base + COORD_W'(d);
        return base - COORD_W'(d);
    endfunction

    function automatic t_message craft_message();
        t_message    m;
        int unsigned pick;
        int unsigned dt;
        int unsigned span;
        m.slot = IDX_W'($urandom_range(IDX_SLOTS - 1, 0));
        m.attack = 1'($urandom_range(1, 0));
        m.x = COORD_W'($urandom);
        m.y = COORD_W'($urandom);
        m.speed = SPEED_W'($urandom);
        m.stamp = $urandom;
        pick = $urandom_range(99, 0);
        if (!sb.slot_valid[m.slot] || pick < 8) return m;
        if (pick < 60) begin
            // plausible travel at the reported speed
            dt = $urandom_range(2000, 1);
            span = int'(m.speed) * dt / 1000;
            m.x = nudge(sb.last_x[m.slot], $urandom_range(span * 7 / 10, 0));
            m.y = nudge(sb.last_y[m.slot], $urandom_range(span * 7 / 10, 0));
            m.stamp = sb.last_time[m.slot] + dt;
        end else if (pick < 75) begin
            // far teleport with little reach
            m.speed = SPEED_W'($urandom_range(200, 1));
            m.stamp = sb.last_time[m.slot] + $urandom_range(50, 1);
        end else if (pick < 88) begin
            // stuck position while claiming to move
            if (sb.moving != SPEED_MAX) begin
                m.speed = SPEED_W'($urandom_range(int'(SPEED_MAX), int'(sb.moving) + 1));
            end
            m.x = nudge(sb.last_x[m.slot], $urandom_range(int'(sb.eps) * 7 / 10, 0));
            m.y = nudge(sb.last_y[m.slot], $urandom_range(int'(sb.eps) * 7 / 10, 0));
            m.stamp = sb.last_time[m.slot] + $urandom_range(5000, 1);
        end else begin
            m.stamp = sb.last_time[m.slot] - $urandom_range(100, 0);
        end
        return m;
    endfunction

    task automatic send_message(input t_message m);
        int unsigned gap;
        gap = calm_send ? 0 : $urandom_range(13, 0);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {m.stamp, m.speed, m.y, m.x, m.slot};
        s_axis_tuser <= m.attack;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        sb.note_message(m);
        if ($urandom_range(39, 0) == 0) calm_send = !calm_send;
    endtask

    task automatic send_fields(input logic [IDX_W-1:0] slot, input logic [COORD_W-1:0] x,
                               input logic [COORD_W-1:0] y, input logic [SPEED_W-1:0] speed,
                               input logic [TIME_W-1:0] stamp, input logic attack);
        t_message m;
        m = '{slot: slot, x: x, y: y, speed: speed, stamp: stamp, attack: attack};
        send_message(m);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_outcomes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic write, input logic [CFG_ADDR_W-1:0] addr,
                              input logic [CFG_DATA_W-1:0] wdata,
                              output logic [CFG_DATA_W-1:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= addr;
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input int unsigned phase);
        logic [CFG_DATA_W-1:0] vals [3];
        logic [CFG_DATA_W-1:0] rdata;
        int unsigned           widths [3];
        widths = '{EPS_W, SPEED_W, SF_W};
        case (phase)
            1: vals = '{32'd1023, 32'd0, 32'd255};
            2: vals = '{32'd0, 32'd16383, 32'd0};
            3: vals = '{32'd1, 32'd16382, 32'd1};
            4: vals = '{$urandom_range(40, 0), $urandom_range(400, 0), $urandom_range(64, 8)};
            default: vals = '{$urandom_range(1023, 0), $urandom_range(16383, 0),
                              $urandom_range(255, 0)};
        endcase
        foreach (vals[i]) begin
            apb_access(1'b1, {CFG_IDX_W'(i), 2'b00}, vals[i] | ($urandom << widths[i]), rdata);
            sb.set_register(CFG_IDX_W'(i), vals[i]);
        end
        // a write past the register list must change nothing
        apb_access(1'b1, {CFG_UNUSED, 2'b00}, $urandom, rdata);
        sb.set_register(CFG_UNUSED, rdata);
        foreach (vals[i]) begin
            apb_access(1'b0, {CFG_IDX_W'(i), 2'b00}, '0, rdata);
            if (rdata !== vals[i]) begin
                sb.report($sformatf("register %0d reads %0d want %0d", i, rdata, vals[i]));
            end
        end
    endtask

    initial begin : result_sink
        int unsigned stall;
        t_outcome    got;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = calm_recv ? 0 : $urandom_range(13, 0);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            got.anomaly = m_axis_tuser[0];
            got.verdict = t_verdict'(m_axis_tuser[3:1]);
            got.counts = t_counts'(m_axis_tdata);
            sb.check_result(got);
            if ($urandom_range(39, 0) == 0) calm_recv = !calm_recv;
        end
    end

    initial begin : watchdog
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || (psel && penable)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("[FAIL] regression broken");
                    $finish;
                end
            end
        end
    end

    initial begin : stimulus
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_fields(0, 0, 0, 0, 0, 0);
        send_fields(63, COORD_MAX, COORD_MAX, SPEED_MAX, 32'hFFFF_FFF0, 1);
        send_fields(0, 0, 0, 100, 10, 1);
        send_fields(0, 0, 0, 50, 10, 1);
        send_fields(0, 0, 0, 51, 10, 0);
        send_fields(0, 0, 0, 51, 5, 0);
        send_fields(0, 1000000, 0, 0, 20, 1);
        send_fields(0, 0, 0, 1, 21, 0);
        send_fields(63, 0, 0, SPEED_MAX, 32'hFFFF_FFFF, 1);
        send_fields(1, 10000, 10000, 1000, 1000, 0);
        // exactly on the reach limit, then one centimetre past it
        send_fields(1, 10900, 11200, 1000, 2000, 0);
        send_fields(1, 11800, 12401, 1000, 3000, 1);
        send_fields(1, 10904, 11200, 51, 3001, 0);
        send_fields(1, 10905, 11200, 51, 3002, 0);
        send_fields(2, 0, COORD_MAX, 0, 0, 1);
        send_fields(2, COORD_MAX, 0, SPEED_MAX, 32'hFFFF_FFFF, 1);

        for (int unsigned phase = 0; phase < PHASES; phase++) begin
            if (phase != 0) begin
                drain();
                configure(phase);
            end
            repeat (PHASE_WORDS) send_message(craft_message());
        end
        drain();

        if (sb.errors == 0 && sb.expected_outcomes.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

@@ sim.f @@
hdl/ppc_pkg.sv
hdl/ppc_ram.sv
hdl/ppc_front.sv
hdl/ppc_queue.sv
hdl/ppc_back.sv
hdl/position_plausibility_checker.sv
hdl/ppc_checker.sv
dv/testbench.sv
